[design/bblc_pkg.sv]
// ============================================================================
// bblc_pkg: shared types and constants of the cache directory
// Holds the table geometry, result codes and the controller/datapath structs.
// ============================================================================
package bblc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam logic [31:0] BUDGET_RESET = 32'd50331648;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_STATS  = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_EVICTED  = 3'd4;
  localparam logic [2:0] ST_STATS    = 3'd5;
  localparam logic [2:0] ST_BYPASS   = 3'd6;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input beat
    logic scan_start; // restart the table scan
    logic scan_step;  // examine one slot
    logic do_hit;     // refresh the matched entry, count a hit
    logic do_miss;    // count a miss
    logic do_evict;   // drop the LRU entry
    logic do_store;   // write the new entry
    logic do_stats;   // clear the counters
    logic [2:0] emit_status; // result code to present
    logic emit;       // load the output register
    logic emit_last;
  } bblc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       enable;
    logic       reject;
    logic       scan_done;
    logic       match_found;
    logic       over_budget;
    logic       lru_found;
    logic       free_found;
  } bblc_stat_t;

endpackage

[design/bblc_datapath.sv]
// ============================================================================
// bblc_datapath: entry table, counters and slot scan
// Scans one slot per cycle for the newest match, the LRU entry and a free slot.
// ============================================================================
module bblc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          in_cmd,
  input  logic [63:0]         in_key,
  input  logic signed [31:0]  in_item_id,
  input  logic [31:0]         in_item_bytes,
  input  bblc_pkg::bblc_cmd_t ctl,
  output bblc_pkg::bblc_stat_t sts,
  output logic [2:0]          res_status,
  output logic [7:0]          res_slot,
  output logic signed [31:0]  res_item_id,
  output logic [31:0]         res_bytes,
  output logic [31:0]         res_hits,
  output logic [31:0]         res_misses,
  output logic                res_last
);

  localparam int unsigned IW = bblc_pkg::IDX_W;
  localparam int unsigned CW = bblc_pkg::CNT_W;

  logic [31:0] budget_r;
  logic        enable_r;
  logic [bblc_pkg::ENTRIES-1:0] valid_r;
  logic [63:0] tag_r    [bblc_pkg::ENTRIES];
  logic [31:0] asset_r  [bblc_pkg::ENTRIES];
  logic [31:0] size_r   [bblc_pkg::ENTRIES];
  logic [63:0] use_r    [bblc_pkg::ENTRIES];
  logic [63:0] ins_r    [bblc_pkg::ENTRIES];
  logic [31:0] total_r, hits_r, misses_r;
  logic [63:0] stamp_r;

  logic [1:0]  cmd_r;
  logic [63:0] key_r;
  logic [31:0] id_r, bytes_r;

  logic [CW-1:0] scan_r;
  logic          mfound_r, lfound_r, ffound_r;
  logic [IW-1:0] midx_r, lidx_r, fidx_r;

  logic [IW-1:0] si;
  logic          mt, lt;

  assign si = scan_r[IW-1:0];
  assign mt = valid_r[si] && (tag_r[si] == key_r) &&
              (!mfound_r || ins_r[si] > ins_r[midx_r]);
  assign lt = valid_r[si] && (!lfound_r || use_r[si] < use_r[lidx_r]);

  always_comb begin
    sts.cmd         = cmd_r;
    sts.enable      = enable_r;
    sts.reject      = (bytes_r == 32'd0) || (bytes_r > {2'b00, budget_r[31:2]});
    sts.scan_done   = (scan_r == CW'(bblc_pkg::ENTRIES));
    sts.match_found = mfound_r;
    sts.over_budget = ({1'b0, total_r} + {1'b0, bytes_r}) > {1'b0, budget_r};
    sts.lru_found   = lfound_r;
    sts.free_found  = ffound_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd; key_r <= in_key; id_r <= in_item_id; bytes_r <= in_item_bytes;
    end
    if (ctl.scan_step && !sts.scan_done) begin
      if (mt) midx_r <= si;
      if (lt) lidx_r <= si;
      if (!valid_r[si] && !ffound_r) fidx_r <= si;
    end
    if (ctl.do_store) begin
      tag_r[fidx_r]   <= key_r;
      asset_r[fidx_r] <= id_r;
      size_r[fidx_r]  <= bytes_r;
      use_r[fidx_r]   <= stamp_r + 64'd1;
      ins_r[fidx_r]   <= stamp_r + 64'd1;
    end
    if (ctl.do_hit) use_r[midx_r] <= stamp_r + 64'd1;
    if (ctl.emit) begin
      res_status <= ctl.emit_status;
      res_last   <= ctl.emit_last;
      res_slot   <= 8'd0; res_item_id <= 32'sd0; res_bytes <= 32'd0;
      res_hits   <= 32'd0; res_misses <= 32'd0;
      case (ctl.emit_status)
        bblc_pkg::ST_HIT: begin
          res_slot <= 8'(midx_r); res_item_id <= asset_r[midx_r];
          res_bytes <= size_r[midx_r];
        end
        bblc_pkg::ST_EVICTED: begin
          res_slot <= 8'(lidx_r); res_item_id <= asset_r[lidx_r];
          res_bytes <= size_r[lidx_r];
        end
        bblc_pkg::ST_STORED: begin
          res_slot <= 8'(fidx_r); res_item_id <= id_r; res_bytes <= bytes_r;
        end
        bblc_pkg::ST_STATS: begin
          res_hits <= hits_r; res_misses <= misses_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= bblc_pkg::BUDGET_RESET;
      enable_r <= 1'b1;
      valid_r  <= '0;
      total_r  <= '0; stamp_r <= '0; hits_r <= '0; misses_r <= '0;
      scan_r   <= '0;
      mfound_r <= 1'b0; lfound_r <= 1'b0; ffound_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bblc_pkg::CFG_BUDGET: budget_r <= cfg_data;
          bblc_pkg::CFG_ENABLE: enable_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (ctl.scan_start) begin
        scan_r <= '0;
        mfound_r <= 1'b0; lfound_r <= 1'b0; ffound_r <= 1'b0;
      end else if (ctl.scan_step && !sts.scan_done) begin
        scan_r <= scan_r + CW'(1);
        if (mt) mfound_r <= 1'b1;
        if (lt) lfound_r <= 1'b1;
        if (!valid_r[si]) ffound_r <= 1'b1;
      end
      if (ctl.do_hit) begin
        stamp_r <= stamp_r + 64'd1;
        hits_r  <= hits_r + 32'd1;
      end
      if (ctl.do_miss) misses_r <= misses_r + 32'd1;
      if (ctl.do_stats) begin
        hits_r <= '0; misses_r <= '0;
      end
      if (ctl.do_evict) begin
        valid_r[lidx_r] <= 1'b0;
        total_r <= total_r - size_r[lidx_r];
      end
      if (ctl.do_store) begin
        valid_r[fidx_r] <= 1'b1;
        total_r <= total_r + bytes_r;
        stamp_r <= stamp_r + 64'd1;
      end
    end
  end

endmodule

[design/bblc_ctrl.sv]
// ============================================================================
// bblc_ctrl: command sequencer of the cache directory
// Steps each command through scans, evictions and the result beats.
// ============================================================================
module bblc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bblc_pkg::bblc_stat_t sts,
  output bblc_pkg::bblc_cmd_t  ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       fullchk_r, fullchk_nxt; // budget met, one full-table check done
  logic       done_r, done_nxt;       // last beat emitted, go idle after it
  logic       ofree;

  assign ofree     = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    fullchk_nxt = fullchk_r;
    done_nxt    = done_r;
    ctl         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (ofree) begin
          if (sts.cmd == bblc_pkg::CMD_STATS) begin
            ctl.emit = 1'b1; ctl.emit_last = 1'b1; ctl.do_stats = 1'b1;
            ctl.emit_status = bblc_pkg::ST_STATS;
            ovalid_nxt = 1'b1; state_nxt = S_WAIT;
          end else if (!sts.enable || sts.cmd[1]) begin
            ctl.emit = 1'b1; ctl.emit_last = 1'b1;
            ctl.emit_status = bblc_pkg::ST_BYPASS;
            ovalid_nxt = 1'b1; state_nxt = S_WAIT;
          end else if (sts.cmd == bblc_pkg::CMD_INSERT && sts.reject) begin
            ctl.emit = 1'b1; ctl.emit_last = 1'b1;
            ctl.emit_status = bblc_pkg::ST_REJECTED;
            ovalid_nxt = 1'b1; state_nxt = S_WAIT;
          end else begin
            ctl.scan_start = 1'b1; fullchk_nxt = 1'b0; state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (ofree) begin
          ovalid_nxt = 1'b1; ctl.emit = 1'b1; state_nxt = S_WAIT;
          if (sts.cmd == bblc_pkg::CMD_LOOKUP) begin
            ctl.emit_last = 1'b1;
            if (sts.match_found) begin
              ctl.do_hit = 1'b1; ctl.emit_status = bblc_pkg::ST_HIT;
            end else begin
              ctl.do_miss = 1'b1; ctl.emit_status = bblc_pkg::ST_MISS;
            end
          end else if (sts.over_budget && sts.lru_found && !fullchk_r) begin
            ctl.do_evict = 1'b1; ctl.emit_status = bblc_pkg::ST_EVICTED;
          end else if (!sts.free_found && sts.lru_found && !fullchk_r) begin
            ctl.do_evict = 1'b1; ctl.emit_status = bblc_pkg::ST_EVICTED;
            fullchk_nxt = 1'b1;
          end else begin
            // A full table with no valid entry cannot occur; the free index is not
            // reset by a scan and would keep its last value in that case.
            ctl.do_store = 1'b1; ctl.emit_last = 1'b1;
            ctl.emit_status = bblc_pkg::ST_STORED;
          end
          done_nxt = ctl.emit_last;
        end
      end
      S_WAIT: begin
        if (ofree) begin
          if (done_r) state_nxt = S_IDLE;
          else begin
            ctl.scan_start = 1'b1; state_nxt = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_DISP && ctl.emit) done_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0; fullchk_r <= 1'b0; done_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt;
      fullchk_r <= fullchk_nxt; done_r <= done_nxt;
    end
  end

endmodule

[design/byte_budget_lru_cache_directory.sv]
// ============================================================================
// byte_budget_lru_cache_directory: directory of a byte-budgeted LRU cache
// Lookup, insert with LRU eviction under a byte budget, and statistics.
// ============================================================================
// Stats, bypass and rejected beats are emitted straight from dispatch;
// lookups and inserts first scan the whole table, and an insert rescans it
// one slot per cycle after every eviction, before its next result beat.
// One item is in flight at a time; the next is taken once its last beat
// leaves the output register. Reset (synchronous, rst_n low) empties the
// table, clears all counters and restores the register defaults.
module byte_budget_lru_cache_directory (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [63:0]        in_key,
  input  logic signed [31:0] in_item_id,
  input  logic [31:0]        in_item_bytes,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [7:0]         out_slot,
  output logic signed [31:0] out_item_id,
  output logic [31:0]        out_bytes,
  output logic [31:0]        out_hit_count,
  output logic [31:0]        out_miss_count,
  output logic               out_last
);

  // The controller sequences commands; the datapath owns the table.
  bblc_pkg::bblc_cmd_t  ctl;
  bblc_pkg::bblc_stat_t sts;

  bblc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .ctl
  );

  bblc_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_cmd, .in_key, .in_item_id, .in_item_bytes,
    .ctl, .sts,
    .res_status(out_status), .res_slot(out_slot), .res_item_id(out_item_id),
    .res_bytes(out_bytes), .res_hits(out_hit_count),
    .res_misses(out_miss_count), .res_last(out_last)
  );

endmodule
